/* rtl/core/qdec_pkg.sv */
// Shared types, constants and helper functions for the quadrature decoder.
`default_nettype none
package qdec_pkg;

    localparam int TIME_W     = 32;
    localparam int THRESH_W   = 16;
    localparam int SCALE_W    = 4;
    localparam int STEP_W     = 5;
    localparam int SUM_W      = 5;
    localparam int AB_W       = 2;
    localparam int QUEUE_DEPTH = 2;

    // Config register indexes (paddr[4:2])
    localparam logic [2:0] REG_TPC         = 3'd0;
    localparam logic [2:0] REG_FAST_BELOW  = 3'd1;
    localparam logic [2:0] REG_MED_BELOW   = 3'd2;
    localparam logic [2:0] REG_FAST_MULT   = 3'd3;
    localparam logic [2:0] REG_MED_MULT    = 3'd4;

    localparam logic [SCALE_W-1:0]  TPC_RST        = 4'd4;
    localparam logic [THRESH_W-1:0] FAST_BELOW_RST = 16'd35;
    localparam logic [THRESH_W-1:0] MED_BELOW_RST  = 16'd80;
    localparam logic [SCALE_W-1:0]  FAST_MULT_RST  = 4'd4;
    localparam logic [SCALE_W-1:0]  MED_MULT_RST   = 4'd2;

    typedef struct packed {
        logic [SCALE_W-1:0]  tpc;
        logic [THRESH_W-1:0] fast_below;
        logic [THRESH_W-1:0] med_below;
        logic [SCALE_W-1:0]  fast_mult;
        logic [SCALE_W-1:0]  med_mult;
    } t_cfg;

    // 4x decode: index is {previous AB, current AB}
    function automatic logic signed [1:0] ab_step(input logic [3:0] idx);
        logic signed [1:0] r;
        case (idx) inside
            4'd1, 4'd7, 4'd8, 4'd14:  r = 2'sb01;
            4'd2, 4'd4, 4'd11, 4'd13: r = 2'sb11;
            default:                  r = 2'sb00;
        endcase
        return r;
    endfunction

    // Clamp a 4-bit setting into 1..8
    function automatic logic [SCALE_W-1:0] sat_1_8(input logic [SCALE_W-1:0] v);
        logic [SCALE_W-1:0] r;
        case (v) inside
            4'd0:         r = 4'd1;
            [4'd9:4'd15]: r = 4'd8;
            default:      r = v;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/qdec_fifo.sv */
// Small register-based queue used between the decoder stages and at the output.
`default_nettype none
module qdec_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/qdec_front.sv */
// Input classifier: drops items for absent channels and packs the rest for the back end.
`default_nettype none
module qdec_front #(
    parameter int CHANNELS = 6,
    parameter int CH_W     = 3,
    parameter int ITEM_W   = 38
) (
    input  wire logic                         i_push,
    input  wire logic                         i_q_full,
    input  wire logic                         i_mode,
    input  wire logic [CH_W-1:0]              i_channel,
    input  wire logic [qdec_pkg::AB_W-1:0]    i_ab_level,
    input  wire logic [qdec_pkg::TIME_W-1:0]  i_now_ms,
    output logic                              o_full,
    output logic                              o_q_push,
    output logic [ITEM_W-1:0]                 o_item
);
    logic in_range;

    assign in_range = ({1'b0, i_channel} < (CH_W + 1)'(CHANNELS));
    assign o_full   = i_q_full;
    // out-of-range channels are taken and dropped here
    assign o_q_push = i_push && !i_q_full && in_range;
    assign o_item   = {i_mode, i_channel, i_ab_level, i_now_ms};

endmodule
`default_nettype wire

/* rtl/core/qdec_back.sv */
// Per-channel decode state, click accumulation and acceleration scaling.
`default_nettype none
module qdec_back #(
    parameter int CHANNELS = 6,
    parameter int CH_W     = 3,
    parameter int ID_W     = 3,
    parameter int ITEM_W   = 38,
    parameter int RES_W    = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire qdec_pkg::t_cfg    i_cfg,
    input  wire logic              i_q_empty,
    input  wire logic [ITEM_W-1:0] i_item,
    output logic                   o_q_pop,
    input  wire logic              i_res_full,
    output logic                   o_res_push,
    output logic [RES_W-1:0]       o_result
);
    localparam int SW = qdec_pkg::SUM_W;

    logic [qdec_pkg::AB_W-1:0]    r_last_ab    [CHANNELS];
    logic signed [SW-1:0]         r_sum        [CHANNELS];
    logic [qdec_pkg::TIME_W-1:0]  r_last_click [CHANNELS];

    logic [qdec_pkg::AB_W-1:0]    n_ab;
    logic signed [SW-1:0]         n_sum;
    logic [qdec_pkg::TIME_W-1:0]  n_click;

    logic                          it_mode;
    logic [CH_W-1:0]               it_ch;
    logic [qdec_pkg::AB_W-1:0]     it_ab;
    logic [qdec_pkg::TIME_W-1:0]   it_now;

    logic                          go;
    logic signed [1:0]             step;
    logic [qdec_pkg::SCALE_W-1:0]  limit;
    logic signed [SW-1:0]          lim_pos, lim_neg, sum_raw, sum_clamp;
    logic                          hit_pos, hit_neg, click;
    logic [qdec_pkg::TIME_W-1:0]   dt;
    logic [qdec_pkg::SCALE_W-1:0]  mult;
    logic signed [qdec_pkg::STEP_W-1:0] mag, value;
    logic [ID_W-1:0]               enc_id;

    assign {it_mode, it_ch, it_ab, it_now} = i_item;

    // one item a cycle whenever an item is waiting and the result queue has room
    assign go      = !i_q_empty && !i_res_full;
    assign o_q_pop = go;

    assign step      = qdec_pkg::ab_step({r_last_ab[it_ch], it_ab});
    assign limit     = qdec_pkg::sat_1_8(i_cfg.tpc);
    assign lim_pos   = $signed({1'b0, limit});
    assign lim_neg   = -lim_pos;
    assign sum_raw   = r_sum[it_ch] + {{(SW - 2){step[1]}}, step};
    assign sum_clamp = (sum_raw > lim_pos) ? lim_pos :
                       (sum_raw < lim_neg) ? lim_neg : sum_raw;
    assign hit_pos   = (sum_clamp >= lim_pos);
    assign hit_neg   = (sum_clamp <= lim_neg);
    assign click     = !it_mode && (step != 2'sb00) && (hit_pos || hit_neg);

    // wrapping interval since this channel's previous click
    assign dt = it_now - r_last_click[it_ch];

    always_comb begin
        if (dt < {{(qdec_pkg::TIME_W - qdec_pkg::THRESH_W){1'b0}}, i_cfg.fast_below}) begin
            mult = qdec_pkg::sat_1_8(i_cfg.fast_mult);
        end else if (dt < {{(qdec_pkg::TIME_W - qdec_pkg::THRESH_W){1'b0}},
                           i_cfg.med_below}) begin
            mult = qdec_pkg::sat_1_8(i_cfg.med_mult);
        end else begin
            mult = qdec_pkg::SCALE_W'(1);
        end
    end

    assign mag    = $signed({1'b0, mult});
    assign value  = hit_pos ? mag : -mag;
    assign enc_id = ID_W'(it_ch) + ID_W'(1);

    assign o_res_push = go && click;
    assign o_result   = {enc_id, value};

    always_comb begin
        n_ab    = it_ab;
        n_sum   = r_sum[it_ch];
        n_click = r_last_click[it_ch];
        if (it_mode) begin
            n_sum   = '0;
            n_click = it_now;
        end else if (click) begin
            n_sum   = '0;
            n_click = it_now;
        end else if (step != 2'sb00) begin
            n_sum = sum_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_last_ab[i]    <= '0;
                r_sum[i]        <= '0;
                r_last_click[i] <= '0;
            end
        end else if (go) begin
            r_last_ab[it_ch]    <= n_ab;
            r_sum[it_ch]        <= n_sum;
            r_last_click[it_ch] <= n_click;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/quadrature_decoder_with_acceleration.sv */
// Top level of the multi-channel quadrature decoder with click acceleration.
`default_nettype none
// Multi-channel rotary quadrature decoder. Each transfer on the input queue
// names a channel, its current A/B levels (A in bit 1) and a millisecond
// timestamp. A sample item (mode 0) decodes the A/B change 4x, accumulates it
// per channel and, once transitions_per_click is reached, emits one click on
// the result queue: encoder_id is channel + 1, step_value is +/-1 times the
// fast, medium or unit multiplier picked from the time since that channel's
// last click. An init item (mode 1) loads A/B and timestamp and clears the
// sum; it never emits. Items for channels >= CHANNELS are taken and dropped.
// Throughput is one item per clock: the front classifier feeds a two-entry
// queue, the back end reads, updates and writes back the channel's state
// registers as it pops each item, and results go into a two-entry output queue.
// An item is registered in the first queue, its click in the output queue. The
// back end stalls only when the output queue is full. Configuration is written
// through the APB port (register i at byte address 4*i) while the block is
// idle; registers 0 and 3..4 are 4 bits, 1..2 are 16 bits.
module quadrature_decoder_with_acceleration #(
    parameter int CHANNELS = 6
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input queue
    input  wire logic       push,
    output logic            full,
    input  wire logic       i_mode,
    input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_channel,
    input  wire logic [1:0] i_ab_level,
    input  wire logic [31:0] i_now_ms,
    // result queue
    output logic            empty,
    input  wire logic       pop,
    output logic [$clog2(CHANNELS + 1)-1:0] o_encoder_id,
    output logic signed [4:0] o_step_value,
    // configuration
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [4:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ID_W   = $clog2(CHANNELS + 1);
    localparam int ITEM_W = 1 + CH_W + qdec_pkg::AB_W + qdec_pkg::TIME_W;
    localparam int RES_W  = ID_W + qdec_pkg::STEP_W;

    // ---------------- configuration registers ----------------
    qdec_pkg::t_cfg r_cfg, n_cfg;
    logic           cfg_wr;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            case (reg_idx)
                qdec_pkg::REG_TPC:        n_cfg.tpc        = pwdata[3:0];
                qdec_pkg::REG_FAST_BELOW: n_cfg.fast_below = pwdata[15:0];
                qdec_pkg::REG_MED_BELOW:  n_cfg.med_below  = pwdata[15:0];
                qdec_pkg::REG_FAST_MULT:  n_cfg.fast_mult  = pwdata[3:0];
                qdec_pkg::REG_MED_MULT:   n_cfg.med_mult   = pwdata[3:0];
                default:                  n_cfg = r_cfg; // unmapped: ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tpc        <= qdec_pkg::TPC_RST;
            r_cfg.fast_below <= qdec_pkg::FAST_BELOW_RST;
            r_cfg.med_below  <= qdec_pkg::MED_BELOW_RST;
            r_cfg.fast_mult  <= qdec_pkg::FAST_MULT_RST;
            r_cfg.med_mult   <= qdec_pkg::MED_MULT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            qdec_pkg::REG_TPC:        prdata = {28'd0, r_cfg.tpc};
            qdec_pkg::REG_FAST_BELOW: prdata = {16'd0, r_cfg.fast_below};
            qdec_pkg::REG_MED_BELOW:  prdata = {16'd0, r_cfg.med_below};
            qdec_pkg::REG_FAST_MULT:  prdata = {28'd0, r_cfg.fast_mult};
            qdec_pkg::REG_MED_MULT:   prdata = {28'd0, r_cfg.med_mult};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- front: classify and enqueue ----------------
    logic              mq_push, mq_full, mq_pop, mq_empty;
    logic [ITEM_W-1:0] mq_wdata, mq_rdata;

    qdec_front #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W),
        .ITEM_W   (ITEM_W)
    ) u_front (
        .i_push     (push),
        .i_q_full   (mq_full),
        .i_mode     (i_mode),
        .i_channel  (i_channel),
        .i_ab_level (i_ab_level),
        .i_now_ms   (i_now_ms),
        .o_full     (full),
        .o_q_push   (mq_push),
        .o_item     (mq_wdata)
    );

    // decouples the classifier from the channel-state update
    qdec_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (qdec_pkg::QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mq_push),
        .i_data  (mq_wdata),
        .o_full  (mq_full),
        .i_pop   (mq_pop),
        .o_data  (mq_rdata),
        .o_empty (mq_empty)
    );

    // ---------------- back: channel state and clicks ----------------
    logic             rq_push, rq_full;
    logic [RES_W-1:0] rq_wdata, rq_rdata;

    qdec_back #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W),
        .ID_W     (ID_W),
        .ITEM_W   (ITEM_W),
        .RES_W    (RES_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (mq_empty),
        .i_item     (mq_rdata),
        .o_q_pop    (mq_pop),
        .i_res_full (rq_full),
        .o_res_push (rq_push),
        .o_result   (rq_wdata)
    );

    // result queue: oldest click sits on the outputs while empty is low
    qdec_fifo #(
        .WIDTH (RES_W),
        .DEPTH (qdec_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (rq_wdata),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_data  (rq_rdata),
        .o_empty (empty)
    );

    assign o_encoder_id = rq_rdata[RES_W-1:qdec_pkg::STEP_W];
    assign o_step_value = $signed(rq_rdata[qdec_pkg::STEP_W-1:0]);

endmodule
`default_nettype wire

/* bench/tb_quadrature_decoder_with_acceleration.sv */
// Self-checking testbench for the multi-channel quadrature decoder with click acceleration.
`timescale 1ns / 1ps

module tb_quadrature_decoder_with_acceleration;

    localparam int          NUM_CH       = 6;
    localparam logic        MODE_SAMPLE  = 1'b0;
    localparam logic        MODE_INIT    = 1'b1;
    localparam int unsigned DRAIN_CYCLES = 6;        // pipe is two deep, leave slack
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned PHASE_ITEMS  = 300;

    // one expected click
    typedef struct packed {
        logic [2:0] encoder_id;
        logic [4:0] step_value;
    } t_click;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_mode;
    logic [2:0]  i_channel;
    logic [1:0]  i_ab_level;
    logic [31:0] i_now_ms;
    logic        empty;
    logic        pop;
    logic [2:0]  o_encoder_id;
    logic signed [4:0] o_step_value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    quadrature_decoder_with_acceleration #(
        .CHANNELS (NUM_CH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_mode       (i_mode),
        .i_channel    (i_channel),
        .i_ab_level   (i_ab_level),
        .i_now_ms     (i_now_ms),
        .empty        (empty),
        .pop          (pop),
        .o_encoder_id (o_encoder_id),
        .o_step_value (o_step_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // --- decoder shadow: settings and per-channel state ---
    logic [3:0]  set_tpc;
    logic [15:0] set_fast_below;
    logic [15:0] set_med_below;
    logic [3:0]  set_fast_mult;
    logic [3:0]  set_med_mult;

    logic [1:0]  ab_hist  [NUM_CH];
    int          tick_sum [NUM_CH];
    logic [31:0] click_ms [NUM_CH];

    t_click      pending_clicks[$];

    // stimulus bookkeeping
    logic [31:0] ch_clock [8];     // per-channel time base, out-of-range channels too
    bit          spin_ccw [NUM_CH];
    bit          tx_calm;
    bit          rx_calm;
    int unsigned rx_hold;
    int unsigned click_count;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    // --- prediction ---

    // 4x decode of {previous, current} A/B; double changes give nothing
    function automatic int quad_delta(logic [1:0] prev, logic [1:0] cur);
        case ({prev, cur})
            4'b0001, 4'b0111, 4'b1110, 4'b1000: return 1;
            4'b0010, 4'b1011, 4'b1101, 4'b0100: return -1;
            default:                            return 0;
        endcase
    endfunction

    // settings of 0 act as 1, anything above 8 acts as 8
    function automatic int clamp_scale(logic [3:0] v);
        if (v == 4'd0) return 1;
        if (v > 4'd8)  return 8;
        return int'(v);
    endfunction

    function automatic void predict_item(logic mode, logic [2:0] ch, logic [1:0] ab,
                                         logic [31:0] now);
        int          delta;
        int          limit;
        int          scale;
        logic [31:0] since;
        t_click      c;
        if (ch >= NUM_CH) return;                   // dropped silently
        if (mode == MODE_INIT) begin
            ab_hist[ch]  = ab;
            tick_sum[ch] = 0;
            click_ms[ch] = now;
            return;
        end
        delta = quad_delta(ab_hist[ch], ab);
        ab_hist[ch] = ab;
        if (delta == 0) return;
        // clamp against the current limit, even if it was lowered mid-count
        limit = clamp_scale(set_tpc);
        tick_sum[ch] = tick_sum[ch] + delta;
        if (tick_sum[ch] > limit)  tick_sum[ch] = limit;
        if (tick_sum[ch] < -limit) tick_sum[ch] = -limit;
        if (tick_sum[ch] > -limit && tick_sum[ch] < limit) return;
        // interval wraps modulo 2^32; fast band is tested first
        since = now - click_ms[ch];
        if (since < {16'd0, set_fast_below})     scale = clamp_scale(set_fast_mult);
        else if (since < {16'd0, set_med_below}) scale = clamp_scale(set_med_mult);
        else                                     scale = 1;
        c.encoder_id = 3'(ch + 3'd1);
        c.step_value = (tick_sum[ch] > 0) ? 5'(scale) : 5'(-scale);
        tick_sum[ch] = 0;
        click_ms[ch] = now;
        pending_clicks.push_back(c);
    endfunction

    function automatic logic [31:0] setting_value(logic [2:0] idx);
        case (idx)
            qdec_pkg::REG_TPC:        return {28'd0, set_tpc};
            qdec_pkg::REG_FAST_BELOW: return {16'd0, set_fast_below};
            qdec_pkg::REG_MED_BELOW:  return {16'd0, set_med_below};
            qdec_pkg::REG_FAST_MULT:  return {28'd0, set_fast_mult};
            qdec_pkg::REG_MED_MULT:   return {28'd0, set_med_mult};
            default:                  return 32'd0;
        endcase
    endfunction

    function automatic void flag_mismatch(string what, logic [31:0] expv, logic [31:0] actv);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0h actual %0h at %0t", what, expv, actv, $time);
    endfunction

    function automatic int unsigned draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    // --- result side ---

    // checker: each popped click against the oldest expectation
    always @(posedge i_clk) begin
        t_click want;
        if (i_rst_n && pop && !empty) begin
            if (pending_clicks.size() == 0) begin
                flag_mismatch("click with none pending", 32'd0,
                              {24'd0, o_encoder_id, o_step_value});
            end else begin
                want = pending_clicks.pop_front();
                if (o_encoder_id !== want.encoder_id)
                    flag_mismatch("encoder_id", {29'd0, want.encoder_id}, {29'd0, o_encoder_id});
                if (o_step_value !== want.step_value)
                    flag_mismatch("step_value", {27'd0, want.step_value}, {27'd0, o_step_value});
            end
            click_count++;
            if (click_count % 32 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            rx_hold = draw_gap(rx_calm);
        end
    end

    // pop is held low for the drawn stall, then high until the next transfer
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            pop <= 1'b0;
            rx_hold--;
        end else begin
            pop <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL quadrature_decoder_with_acceleration");
            $finish;
        end
    end

    // --- drive side ---

    // one input transfer; push stays high across back-to-back items
    task automatic send_item(logic mode, logic [2:0] ch, logic [1:0] ab, logic [31:0] now);
        int unsigned gap;
        gap = draw_gap(tx_calm);
        if (gap != 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push       <= 1'b1;
        i_mode     <= mode;
        i_channel  <= ch;
        i_ab_level <= ab;
        i_now_ms   <= now;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_item(mode, ch, ab, now);
    endtask

    // stop sending and let every expected click drain out
    task automatic wait_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_clicks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write then, for mapped registers, read-back; only called while idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            qdec_pkg::REG_TPC:        set_tpc        = value[3:0];
            qdec_pkg::REG_FAST_BELOW: set_fast_below = value[15:0];
            qdec_pkg::REG_MED_BELOW:  set_med_below  = value[15:0];
            qdec_pkg::REG_FAST_MULT:  set_fast_mult  = value[3:0];
            qdec_pkg::REG_MED_MULT:   set_med_mult   = value[3:0];
            default: ;                                   // unmapped, ignored
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= qdec_pkg::REG_MED_MULT) begin
            @(negedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            if (prdata !== setting_value(idx))
                flag_mismatch("register read-back", setting_value(idx), prdata);
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic apply_settings(logic [3:0] tpc, logic [15:0] fast_below,
                                  logic [15:0] med_below, logic [3:0] fast_mult,
                                  logic [3:0] med_mult);
        write_reg(qdec_pkg::REG_TPC,        {28'd0, tpc});
        write_reg(qdec_pkg::REG_FAST_BELOW, {16'd0, fast_below});
        write_reg(qdec_pkg::REG_MED_BELOW,  {16'd0, med_below});
        write_reg(qdec_pkg::REG_FAST_MULT,  {28'd0, fast_mult});
        write_reg(qdec_pkg::REG_MED_MULT,   {28'd0, med_mult});
    endtask

    // next Gray state: 0,1,3,2 counts up, the reverse counts down
    function automatic logic [1:0] gray_next(logic [1:0] ab, bit ccw);
        case (ab)
            2'b00:   return ccw ? 2'b10 : 2'b01;
            2'b01:   return ccw ? 2'b00 : 2'b11;
            2'b11:   return ccw ? 2'b01 : 2'b10;
            default: return ccw ? 2'b11 : 2'b00;
        endcase
    endfunction

    // --- tests ---

    // field extremes, both operations, wrap of the click interval,
    // no-change and double-change samples, out-of-range channels
    task automatic test_directed_cases();
        send_item(MODE_INIT,   3'd0, 2'b00, 32'h0000_0000);
        send_item(MODE_SAMPLE, 3'd0, 2'b01, 32'h0000_0000);
        send_item(MODE_SAMPLE, 3'd0, 2'b11, 32'h0000_0002);
        send_item(MODE_SAMPLE, 3'd0, 2'b11, 32'h0000_0003);   // no change
        send_item(MODE_SAMPLE, 3'd0, 2'b10, 32'h0000_0005);
        send_item(MODE_SAMPLE, 3'd0, 2'b00, 32'h0000_000A);   // click, fast
        send_item(MODE_SAMPLE, 3'd0, 2'b11, 32'h0000_000B);   // double change
        send_item(MODE_SAMPLE, 3'd7, 2'b01, 32'hFFFF_FFFF);   // ignored channel
        send_item(MODE_INIT,   3'd6, 2'b11, 32'hFFFF_FFFF);   // ignored channel
        send_item(MODE_SAMPLE, 3'd6, 2'b10, 32'h5555_5555);
        send_item(MODE_INIT,   3'd7, 2'b00, 32'hAAAA_AAAA);
        // counter-clockwise click across the 2^32 wrap: medium band
        send_item(MODE_INIT,   3'd5, 2'b11, 32'hFFFF_FFF0);
        send_item(MODE_SAMPLE, 3'd5, 2'b01, 32'hFFFF_FFF8);
        send_item(MODE_SAMPLE, 3'd5, 2'b00, 32'h0000_0000);
        send_item(MODE_SAMPLE, 3'd5, 2'b10, 32'h0000_0010);
        send_item(MODE_SAMPLE, 3'd5, 2'b11, 32'h0000_0030);
        // from reset state, long interval: unit scale
        send_item(MODE_SAMPLE, 3'd3, 2'b01, 32'h7FFF_FFFF);
        send_item(MODE_SAMPLE, 3'd3, 2'b11, 32'h8000_0000);
        send_item(MODE_SAMPLE, 3'd3, 2'b10, 32'h8000_0001);
        send_item(MODE_SAMPLE, 3'd3, 2'b00, 32'hFFFF_FFFF);
        // back and forth without reaching the limit
        send_item(MODE_SAMPLE, 3'd2, 2'b10, 32'h0000_1234);
        send_item(MODE_SAMPLE, 3'd2, 2'b00, 32'h0000_1235);
        send_item(MODE_INIT,   3'd4, 2'b01, 32'h0F0F_0F0F);
        wait_idle();
    endtask

    // limit lowered while a partial count is held: clamp still fires the click
    task automatic test_limit_lowered();
        write_reg(qdec_pkg::REG_TPC, 32'd8);
        send_item(MODE_INIT,   3'd1, 2'b00, 32'd1000);
        send_item(MODE_SAMPLE, 3'd1, 2'b01, 32'd1010);
        send_item(MODE_SAMPLE, 3'd1, 2'b11, 32'd1020);
        send_item(MODE_SAMPLE, 3'd1, 2'b10, 32'd1030);
        wait_idle();
        write_reg(qdec_pkg::REG_TPC, 32'd2);
        send_item(MODE_SAMPLE, 3'd1, 2'b00, 32'd1100);
        wait_idle();
    endtask

    // unmapped addresses must not disturb the real registers
    task automatic test_unknown_registers();
        for (int r = int'(qdec_pkg::REG_MED_MULT) + 1; r < 8; r++)
            write_reg(3'(r), 32'hFFFF_FFFF);
        send_item(MODE_INIT,   3'd2, 2'b00, 32'd0);
        send_item(MODE_SAMPLE, 3'd2, 2'b10, 32'd1);
        send_item(MODE_SAMPLE, 3'd2, 2'b11, 32'd2);
        wait_idle();
    endtask

    // one random item: mostly clean rotation, some inits, noise and dropped channels
    // returns 1 when the item targets a real channel
    task automatic random_item(output bit counted);
        int unsigned kind;
        logic [2:0]  ch;
        logic [1:0]  ab;
        logic        mode;
        kind = $urandom_range(0, 99);
        ch   = (kind < 6) ? 3'(NUM_CH + $urandom_range(0, 1))
                          : 3'($urandom_range(0, NUM_CH - 1));
        case ($urandom_range(0, 19))
            0:          ch_clock[ch] = ch_clock[ch] + $urandom;
            1, 2, 3, 4: ch_clock[ch] = ch_clock[ch] + $urandom_range(0, 40);
            default:    ch_clock[ch] = ch_clock[ch] + $urandom_range(0, 12);
        endcase
        mode = MODE_SAMPLE;
        if (kind < 6) begin
            mode = 1'($urandom_range(0, 1));
            ab   = 2'($urandom_range(0, 3));
        end else if (kind < 12) begin
            mode = MODE_INIT;
            ab   = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) ch_clock[ch] = $urandom;
        end else if (kind < 22) begin
            ab = 2'($urandom_range(0, 3));                 // noise: stay, double, or step
        end else begin
            if ($urandom_range(0, 15) == 0) spin_ccw[ch] = !spin_ccw[ch];
            ab = gray_next(ab_hist[ch], spin_ccw[ch]);
        end
        send_item(mode, ch, ab, ch_clock[ch]);
        counted = (ch < NUM_CH);
    endtask

    task automatic random_phase(int unsigned items);
        int unsigned done;
        bit          counted;
        done = 0;
        while (done < items) begin
            if (done % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
            random_item(counted);
            if (counted) begin
                done++;
                // sender holds off mid-phase until every click is back
                if (done == items / 2) wait_idle();
            end
        end
        wait_idle();
    endtask

    // random rotation under a sweep of settings, extremes included
    task automatic test_random_rotation();
        for (int c = 0; c < 8; c++) ch_clock[c] = $urandom;
        apply_settings(qdec_pkg::TPC_RST, qdec_pkg::FAST_BELOW_RST,
                       qdec_pkg::MED_BELOW_RST, qdec_pkg::FAST_MULT_RST,
                       qdec_pkg::MED_MULT_RST);
        random_phase(PHASE_ITEMS);
        // never fast, nearly always medium, widest scale
        apply_settings(4'd1, 16'd0, 16'hFFFF, 4'd1, 4'd8);
        random_phase(PHASE_ITEMS);
        // thresholds out of order, out-of-range limit and fast scale
        apply_settings(4'd15, 16'hFFFF, 16'd100, 4'd15, 4'd0);
        random_phase(PHASE_ITEMS);
        // zero limit and zero fast scale, empty medium band
        apply_settings(4'd0, 16'd20, 16'd20, 4'd0, 4'd15);
        random_phase(PHASE_ITEMS);
        apply_settings(4'd2, 16'd12, 16'd60, 4'd3, 4'd5);
        random_phase(PHASE_ITEMS);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        i_mode         = MODE_SAMPLE;
        i_channel      = 3'd0;
        i_ab_level     = 2'b00;
        i_now_ms       = 32'd0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 5'd0;
        pwdata         = 32'd0;
        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        rx_hold        = 0;
        click_count    = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        set_tpc        = qdec_pkg::TPC_RST;
        set_fast_below = qdec_pkg::FAST_BELOW_RST;
        set_med_below  = qdec_pkg::MED_BELOW_RST;
        set_fast_mult  = qdec_pkg::FAST_MULT_RST;
        set_med_mult   = qdec_pkg::MED_MULT_RST;
        for (int c = 0; c < NUM_CH; c++) begin
            ab_hist[c]  = 2'b00;
            tick_sum[c] = 0;
            click_ms[c] = 32'd0;
            spin_ccw[c] = 1'b0;
        end
        for (int c = 0; c < 8; c++) ch_clock[c] = 32'd0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_limit_lowered();
        test_unknown_registers();
        test_random_rotation();
        wait_idle();

        if (mismatch_count == 0 && pending_clicks.size() == 0) begin
            $display("PASS quadrature_decoder_with_acceleration");
        end else begin
            $display("FAIL quadrature_decoder_with_acceleration");
        end
        $finish;
    end

endmodule
